// ===== sv/stereo_source_gain_pan_defines.svh =====
// ----------------------------------------------------------------------------
// Stereo source gain/pan assertion macros
// Concurrent assertion helpers for stereo_source_gain_pan; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_SOURCE_GAIN_PAN_DEFINES_SVH
`define STEREO_SOURCE_GAIN_PAN_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define SSGP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssgp: assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define SSGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssgp: assertion failed");
`else
`define SSGP_ASSERT_IMPL(label, ante, cons)
`define SSGP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/ssgp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssgp_pkg
// Constants and types shared by the stereo source gain/pan pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssgp_pkg;

    // configuration register
    localparam int MD_W = 23;
    localparam logic [MD_W-1:0] MAX_DIST_RESET = 23'd12800;

    // output field width
    localparam int OUT_W = 16;

    // quarter-sine polynomial coefficients, Q.30
    localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;
    localparam logic [29:0] Q30_B_COEF  = 30'd688904866;
    localparam logic [26:0] Q30_C_COEF  = 27'd76016977;

    // range-reduced deltas and the range shift count
    localparam int SHIFT_W = 4;
    localparam int DELTA_W = 26;

    // square root: radicand and root widths
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // divider quotient bits
    localparam int DIV_Q_W = 17;

    // data that rides alongside the square root stages
    typedef struct packed {
        logic                      zero;
        logic [SHIFT_W-1:0]        sh;
        logic signed [DELTA_W-1:0] sdx;
        logic signed [DELTA_W-1:0] sdy;
        logic signed [31:0]        c;
        logic signed [31:0]        s;
    } side_t;

    // data that rides alongside the divider stages
    typedef struct packed {
        logic zero;
        logic negf;
        logic negr;
    } dside_t;

endpackage

`default_nettype wire

// ===== sv/ssgp_if.sv =====
// ----------------------------------------------------------------------------
// ssgp channel interfaces
// Valid/ready channels for position requests and gain/pan results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssgp_in_if #(parameter int POSITION_BITS = 24) ();
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] listener_x;
    logic signed [POSITION_BITS-1:0] listener_y;
    logic [15:0]                     listener_heading;
    logic signed [POSITION_BITS-1:0] source_x;
    logic signed [POSITION_BITS-1:0] source_y;

    modport source (output valid, listener_x, listener_y, listener_heading,
                    source_x, source_y, input ready);
    modport sink (input valid, listener_x, listener_y, listener_heading,
                  source_x, source_y, output ready);
endinterface

interface ssgp_out_if ();
    logic        valid;
    logic        ready;
    logic [15:0] volume;
    logic [15:0] pan;

    modport source (output valid, volume, pan, input ready);
    modport sink (input valid, volume, pan, output ready);
endinterface

`default_nettype wire

// ===== sv/ssgp_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssgp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgp_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ssgp_pkg::RAD_W-1:0]  rad,
    output logic [ssgp_pkg::ROOT_W-1:0] root
);
    import ssgp_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg [0:ROOT_W-2];
    logic [REM_W-1:0]  rem_reg [0:ROOT_W-2];
    logic [ROOT_W-1:0] q_reg   [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_step
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] q_in;
            logic [REM_W+1:0]  cur;
            logic [REM_W+1:0]  trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign rad_in = rad;
                assign rem_in = '0;
                assign q_in   = '0;
            end
            else
            begin : g_later
                assign rad_in = rad_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            // bring down two radicand bits, try root*4+1
            assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
            assign trial = (REM_W+2)'({q_in, 2'b01});
            assign take  = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[k] <= {q_in[ROOT_W-2:0], take};
                end
            end

            if (k < ROOT_W-1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[k] <= rad_in << 2;
                        rem_reg[k] <= take ? REM_W'(cur - trial) : REM_W'(cur);
                    end
                end
            end
        end
    endgenerate

    assign root = q_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== sv/ssgp_div.sv =====
// ----------------------------------------------------------------------------
// ssgp_div
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgp_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 48,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             ovf
);
    localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic [CW-1:0]    rem_reg [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [1:Q_W];
    logic             ovf_reg [0:Q_W];

    // entry stage: flag quotients that do not fit in Q_W bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            den_reg[0] <= den;
            ovf_reg[0] <= (CW'(num) >= (CW'(den) << Q_W));
        end
    end

    genvar j;
    generate
        for (j = 1; j <= Q_W; j++)
        begin : g_bit
            logic [CW-1:0] shifted;
            logic          ge;

            assign shifted = CW'(den_reg[j-1]) << (Q_W - j);
            assign ge      = (rem_reg[j-1] >= shifted);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ovf_reg[j] <= ovf_reg[j-1];
                end
            end

            if (j == 1)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[j] <= Q_W'(ge);
                    end
                end
            end
            else
            begin : g_later
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[j] <= {q_reg[j-1][Q_W-2:0], ge};
                    end
                end
            end

            if (j < Q_W)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j] <= ge ? (rem_reg[j-1] - shifted) : rem_reg[j-1];
                        den_reg[j] <= den_reg[j-1];
                    end
                end
            end
        end
    endgenerate

    assign quo = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

`default_nettype wire

// ===== sv/stereo_source_gain_pan.sv =====
// ----------------------------------------------------------------------------
// stereo_source_gain_pan
// Distance gain and stereo pan of one sound source for one listener.
// ----------------------------------------------------------------------------
// Usage:
//   voice (sink): listener x/y, listener heading and source x/y, one request
//     per valid/ready handshake. mix (source): volume and pan, Q0.16.
//   cfg_we/cfg_wdata write max_distance (Q15.8); write it only while no
//   request is in flight.
//   From an accepted request to mix.valid the pipeline has five setup
//   stages (delta, range shift, squares, sum, trig), a 32-stage square root
//   (one root bit per stage), three product/sum/magnitude stages, an 18-stage
//   divider (overflow check plus one quotient bit per stage), two finishing
//   stages and the output register.
//   One request per cycle unless the skid is full; every stage is a register.
//   Reset (rst_n low, asynchronous) empties the pipeline and sets max_distance
//   to 50.0. When mix stalls, the output register and a skid register hold
//   two results; voice.ready drops only while the skid register is full, and
//   the whole pipeline then freezes with nothing lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_source_gain_pan_defines.svh"

module stereo_source_gain_pan #(
    parameter int POSITION_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ssgp_pkg::MD_W-1:0] cfg_wdata,
    ssgp_in_if.sink                   voice,
    ssgp_out_if.source                mix
);
    import ssgp_pkg::*;

    localparam int DW     = POSITION_BITS + 1;
    localparam int SH_MAX = (POSITION_BITS > 24) ? POSITION_BITS - 24 : 0;
    localparam int XW     = ((DW > DELTA_W) ? DW : DELTA_W) + 1;
    localparam logic signed [XW-1:0] LIM_POS = XW'(33554432);
    localparam logic signed [XW-1:0] LIM_NEG = -LIM_POS;

    logic adv;

    // configuration register
    logic [MD_W-1:0] md_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg <= MAX_DIST_RESET;
        end
        else if (cfg_we)
        begin
            md_reg <= cfg_wdata;
        end
    end

    // valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic sq_valid_reg [0:ROOT_W-1];
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic dv_valid_reg [0:DIV_Q_W];
    logic p4_valid_reg, p5_valid_reg;

    // stage 1: deltas
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic [15:0]          s1_head_reg;

    // stage 2: range shift, |delta|, z^2
    logic signed [XW-1:0]      dx_ext, dy_ext, dx_sh, dy_sh;
    logic [SHIFT_W-1:0]        sh_next;
    logic signed [DELTA_W-1:0] sdx_next, sdy_next;
    logic [DELTA_W-1:0]        ax_full, ay_full;
    logic [14:0]               zs_next, zc_next;
    logic [29:0]               zs_sq, zc_sq;

    logic [SHIFT_W-1:0]        s2_sh_reg;
    logic signed [DELTA_W-1:0] s2_sdx_reg, s2_sdy_reg;
    logic [24:0]               s2_ax_reg, s2_ay_reg;
    logic [14:0]               s2_zs_reg, s2_zc_reg, s2_z2s_reg, s2_z2c_reg;
    logic [1:0]                s2_quad_reg;

    // stage 3: squares, C*z^2
    logic [41:0]               ts_prod, tc_prod;
    logic [49:0]               s3_axx_reg, s3_ayy_reg;
    logic [27:0]               s3_ts_reg, s3_tc_reg;
    logic [SHIFT_W-1:0]        s3_sh_reg;
    logic signed [DELTA_W-1:0] s3_sdx_reg, s3_sdy_reg;
    logic [14:0]               s3_zs_reg, s3_zc_reg, s3_z2s_reg, s3_z2c_reg;
    logic [1:0]                s3_quad_reg;

    // stage 4: d^2, (B - C*z^2)*z^2
    logic [29:0]               inner_s, inner_c;
    logic [44:0]               ms_prod, mc_prod;
    logic [50:0]               s4_d2_reg;
    logic [30:0]               s4_ms_reg, s4_mc_reg;
    logic [SHIFT_W-1:0]        s4_sh_reg;
    logic signed [DELTA_W-1:0] s4_sdx_reg, s4_sdy_reg;
    logic [14:0]               s4_zs_reg, s4_zc_reg;
    logic [1:0]                s4_quad_reg;

    // stage 5: quarter sine and cosine
    logic [30:0]               mid_s, mid_c;
    logic [45:0]               qs_prod, qc_prod;
    logic [50:0]               s5_d2_reg;
    logic                      s5_zero_reg;
    logic [30:0]               s5_qs_reg, s5_qc_reg;
    logic [SHIFT_W-1:0]        s5_sh_reg;
    logic signed [DELTA_W-1:0] s5_sdx_reg, s5_sdy_reg;
    logic [1:0]                s5_quad_reg;

    // square root and its side data
    side_t             side_next;
    side_t             side_reg [0:ROOT_W-1];
    side_t             side_out;
    logic [ROOT_W-1:0] e_root;

    // post-root stages
    logic signed [57:0] p1_pdxc_reg, p1_pdys_reg, p1_pdyc_reg, p1_pdxs_reg;
    logic [ROOT_W-1:0]  p1_e_reg;
    logic [40:0]        p1_denv_reg;
    logic               p1_zero_reg;

    logic signed [58:0] p2_numf_reg, p2_numr_reg;
    logic [ROOT_W-1:0]  p2_e_reg;
    logic [40:0]        p2_denv_reg;
    logic               p2_zero_reg;

    logic [58:0]        p3_magf_reg, p3_magr_reg;
    logic               p3_negf_reg, p3_negr_reg;
    logic [47:0]        p3_denfr_reg;
    logic [40:0]        p3_denv_reg;
    logic               p3_zero_reg;

    // dividers
    logic [DIV_Q_W-1:0] qf, qr, qv;
    logic               ovf_f, ovf_r, ovf_v;
    dside_t             dside_reg [0:DIV_Q_W];

    // finishing
    logic [16:0] fmag_next, rmag_next;
    logic [17:0] pan_sum;
    logic [16:0] pan_half;
    logic [15:0] vol_next, pan_next;

    logic        p4_zero_reg, p4_fneg_reg;
    logic [16:0] p4_fmag_reg;
    logic [15:0] p4_vol_reg, p4_pan_reg;

    logic [17:0] rear_factor;
    logic [33:0] rear_prod;
    logic [15:0] p5_volume_reg, p5_pan_reg;

    // output register and skid
    logic        out_valid_reg, skid_valid_reg;
    logic [15:0] out_volume_reg, out_pan_reg, skid_volume_reg, skid_pan_reg;

    // the pipeline moves whenever the skid register is free
    assign adv         = !skid_valid_reg;
    assign voice.ready = adv;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            for (int i = 0; i < ROOT_W; i++)
            begin
                sq_valid_reg[i] <= 1'b0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_Q_W; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= voice.valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            sq_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            end
            p1_valid_reg    <= sq_valid_reg[ROOT_W-1];
            p2_valid_reg    <= p1_valid_reg;
            p3_valid_reg    <= p2_valid_reg;
            dv_valid_reg[0] <= p3_valid_reg;
            for (int i = 1; i <= DIV_Q_W; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            p4_valid_reg    <= dv_valid_reg[DIV_Q_W];
            p5_valid_reg    <= p4_valid_reg;
        end
    end

    // stage 1: source minus listener
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg   <= $signed({voice.source_x[POSITION_BITS-1], voice.source_x})
                         - $signed({voice.listener_x[POSITION_BITS-1], voice.listener_x});
            s1_dy_reg   <= $signed({voice.source_y[POSITION_BITS-1], voice.source_y})
                         - $signed({voice.listener_y[POSITION_BITS-1], voice.listener_y});
            s1_head_reg <= voice.listener_heading;
        end
    end

    // stage 2: smallest floor shift that brings both deltas under 2^25
    assign dx_ext = XW'(s1_dx_reg);
    assign dy_ext = XW'(s1_dy_reg);

    always_comb
    begin
        sh_next = '0;
        for (int k = SH_MAX; k >= 0; k--)
        begin
            if (((dx_ext >>> k) < LIM_POS) && ((dx_ext >>> k) > LIM_NEG) &&
                ((dy_ext >>> k) < LIM_POS) && ((dy_ext >>> k) > LIM_NEG))
            begin
                sh_next = SHIFT_W'(k);
            end
        end
    end

    assign dx_sh    = dx_ext >>> sh_next;
    assign dy_sh    = dy_ext >>> sh_next;
    assign sdx_next = dx_sh[DELTA_W-1:0];
    assign sdy_next = dy_sh[DELTA_W-1:0];
    assign ax_full  = sdx_next[DELTA_W-1] ? DELTA_W'(-sdx_next) : DELTA_W'(sdx_next);
    assign ay_full  = sdy_next[DELTA_W-1] ? DELTA_W'(-sdy_next) : DELTA_W'(sdy_next);

    // angle within the quadrant, for sine and for cosine
    assign zs_next = {1'b0, s1_head_reg[13:0]};
    assign zc_next = 15'd16384 - zs_next;
    assign zs_sq   = zs_next * zs_next;
    assign zc_sq   = zc_next * zc_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sh_reg   <= sh_next;
            s2_sdx_reg  <= sdx_next;
            s2_sdy_reg  <= sdy_next;
            s2_ax_reg   <= ax_full[24:0];
            s2_ay_reg   <= ay_full[24:0];
            s2_zs_reg   <= zs_next;
            s2_zc_reg   <= zc_next;
            s2_z2s_reg  <= zs_sq[28:14];
            s2_z2c_reg  <= zc_sq[28:14];
            s2_quad_reg <= s1_head_reg[15:14];
        end
    end

    // stage 3: squares of the deltas, C*z^2
    assign ts_prod = 42'(Q30_C_COEF) * 42'(s2_z2s_reg);
    assign tc_prod = 42'(Q30_C_COEF) * 42'(s2_z2c_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_axx_reg  <= 50'(s2_ax_reg) * 50'(s2_ax_reg);
            s3_ayy_reg  <= 50'(s2_ay_reg) * 50'(s2_ay_reg);
            s3_ts_reg   <= ts_prod[41:14];
            s3_tc_reg   <= tc_prod[41:14];
            s3_sh_reg   <= s2_sh_reg;
            s3_sdx_reg  <= s2_sdx_reg;
            s3_sdy_reg  <= s2_sdy_reg;
            s3_zs_reg   <= s2_zs_reg;
            s3_zc_reg   <= s2_zc_reg;
            s3_z2s_reg  <= s2_z2s_reg;
            s3_z2c_reg  <= s2_z2c_reg;
            s3_quad_reg <= s2_quad_reg;
        end
    end

    // stage 4: squared distance, second polynomial term
    assign inner_s = Q30_B_COEF - 30'(s3_ts_reg);
    assign inner_c = Q30_B_COEF - 30'(s3_tc_reg);
    assign ms_prod = 45'(inner_s) * 45'(s3_z2s_reg);
    assign mc_prod = 45'(inner_c) * 45'(s3_z2c_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_d2_reg   <= 51'(s3_axx_reg) + 51'(s3_ayy_reg);
            s4_ms_reg   <= ms_prod[44:14];
            s4_mc_reg   <= mc_prod[44:14];
            s4_sh_reg   <= s3_sh_reg;
            s4_sdx_reg  <= s3_sdx_reg;
            s4_sdy_reg  <= s3_sdy_reg;
            s4_zs_reg   <= s3_zs_reg;
            s4_zc_reg   <= s3_zc_reg;
            s4_quad_reg <= s3_quad_reg;
        end
    end

    // stage 5: quarter sine and cosine magnitudes
    assign mid_s   = Q30_HALF_PI - s4_ms_reg;
    assign mid_c   = Q30_HALF_PI - s4_mc_reg;
    assign qs_prod = 46'(mid_s) * 46'(s4_zs_reg);
    assign qc_prod = 46'(mid_c) * 46'(s4_zc_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_d2_reg   <= s4_d2_reg;
            s5_zero_reg <= (s4_d2_reg == '0);
            s5_qs_reg   <= qs_prod[44:14];
            s5_qc_reg   <= qc_prod[44:14];
            s5_sh_reg   <= s4_sh_reg;
            s5_sdx_reg  <= s4_sdx_reg;
            s5_sdy_reg  <= s4_sdy_reg;
            s5_quad_reg <= s4_quad_reg;
        end
    end

    // heading quadrant sets signs and sine/cosine swap
    always_comb
    begin
        side_next.zero = s5_zero_reg;
        side_next.sh   = s5_sh_reg;
        side_next.sdx  = s5_sdx_reg;
        side_next.sdy  = s5_sdy_reg;
        case (s5_quad_reg)
            2'd0:
            begin
                side_next.c = 32'(s5_qc_reg);
                side_next.s = 32'(s5_qs_reg);
            end
            2'd1:
            begin
                side_next.c = -32'(s5_qs_reg);
                side_next.s = 32'(s5_qc_reg);
            end
            2'd2:
            begin
                side_next.c = -32'(s5_qc_reg);
                side_next.s = -32'(s5_qs_reg);
            end
            default:
            begin
                side_next.c = 32'(s5_qs_reg);
                side_next.s = -32'(s5_qc_reg);
            end
        endcase
    end

    // distance in Q.14: sqrt(d^2 * 2^12)
    ssgp_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  ({1'b0, s5_d2_reg, 12'd0}),
        .root (e_root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < ROOT_W; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_out = side_reg[ROOT_W-1];

    // post stage 1: direction products, attenuation denominator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_pdxc_reg <= 58'(side_out.sdx) * 58'(side_out.c);
            p1_pdys_reg <= 58'(side_out.sdy) * 58'(side_out.s);
            p1_pdyc_reg <= 58'(side_out.sdy) * 58'(side_out.c);
            p1_pdxs_reg <= 58'(side_out.sdx) * 58'(side_out.s);
            p1_e_reg    <= e_root;
            p1_denv_reg <= 41'({md_reg, 6'd0}) + (41'(e_root) << side_out.sh);
            p1_zero_reg <= side_out.zero;
        end
    end

    // post stage 2: forward and right numerators
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_numf_reg <= 59'(p1_pdxc_reg) + 59'(p1_pdys_reg);
            p2_numr_reg <= 59'(p1_pdyc_reg) - 59'(p1_pdxs_reg);
            p2_e_reg    <= p1_e_reg;
            p2_denv_reg <= p1_denv_reg;
            p2_zero_reg <= p1_zero_reg;
        end
    end

    // post stage 3: sign and magnitude for the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_magf_reg  <= p2_numf_reg[58] ? 59'(-p2_numf_reg) : 59'(p2_numf_reg);
            p3_magr_reg  <= p2_numr_reg[58] ? 59'(-p2_numr_reg) : 59'(p2_numr_reg);
            p3_negf_reg  <= p2_numf_reg[58];
            p3_negr_reg  <= p2_numr_reg[58];
            p3_denfr_reg <= {p2_e_reg, 16'd0};
            p3_denv_reg  <= p2_denv_reg;
            p3_zero_reg  <= p2_zero_reg;
        end
    end

    ssgp_div #(.NUM_W(59), .DEN_W(48), .Q_W(DIV_Q_W)) u_div_f (
        .clk (clk),
        .en  (adv),
        .num (p3_magf_reg),
        .den (p3_denfr_reg),
        .quo (qf),
        .ovf (ovf_f)
    );

    ssgp_div #(.NUM_W(59), .DEN_W(48), .Q_W(DIV_Q_W)) u_div_r (
        .clk (clk),
        .en  (adv),
        .num (p3_magr_reg),
        .den (p3_denfr_reg),
        .quo (qr),
        .ovf (ovf_r)
    );

    ssgp_div #(.NUM_W(45), .DEN_W(41), .Q_W(DIV_Q_W)) u_div_v (
        .clk (clk),
        .en  (adv),
        .num ({md_reg, 22'd0}),
        .den (p3_denv_reg),
        .quo (qv),
        .ovf (ovf_v)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= '{zero: p3_zero_reg, negf: p3_negf_reg, negr: p3_negr_reg};
            for (int i = 1; i <= DIV_Q_W; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // post stage 4: clamp quotients, pan
    assign fmag_next = (ovf_f || (qf > 17'd65536)) ? 17'd65536 : qf;
    assign rmag_next = (ovf_r || (qr > 17'd65536)) ? 17'd65536 : qr;
    assign vol_next  = (ovf_v || (qv > 17'd65535)) ? 16'hFFFF : qv[15:0];
    assign pan_sum   = dside_reg[DIV_Q_W].negr ? (18'd65536 - 18'(rmag_next))
                                               : (18'd65536 + 18'(rmag_next));
    assign pan_half  = pan_sum[17:1];
    assign pan_next  = (pan_half > 17'd65535) ? 16'hFFFF : pan_half[15:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_zero_reg <= dside_reg[DIV_Q_W].zero;
            p4_fneg_reg <= dside_reg[DIV_Q_W].negf && (fmag_next != '0);
            p4_fmag_reg <= fmag_next;
            p4_vol_reg  <= vol_next;
            p4_pan_reg  <= pan_next;
        end
    end

    // post stage 5: rear attenuation, zero-distance override
    assign rear_factor = 18'd131072 - 18'(p4_fmag_reg);
    assign rear_prod   = 34'(p4_vol_reg) * 34'(rear_factor);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (p4_zero_reg)
            begin
                p5_volume_reg <= 16'hFFFF;
                p5_pan_reg    <= 16'h8000;
            end
            else
            begin
                p5_volume_reg <= p4_fneg_reg ? rear_prod[32:17] : p4_vol_reg;
                p5_pan_reg    <= p4_pan_reg;
            end
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (mix.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (p5_valid_reg)
        begin
            if (out_valid_reg && !mix.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (mix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (mix.ready)
            begin
                out_volume_reg <= skid_volume_reg;
                out_pan_reg    <= skid_pan_reg;
            end
        end
        else if (p5_valid_reg)
        begin
            if (out_valid_reg && !mix.ready)
            begin
                skid_volume_reg <= p5_volume_reg;
                skid_pan_reg    <= p5_pan_reg;
            end
            else
            begin
                out_volume_reg <= p5_volume_reg;
                out_pan_reg    <= p5_pan_reg;
            end
        end
    end

    assign mix.valid  = out_valid_reg;
    assign mix.volume = out_volume_reg;
    assign mix.pan    = out_pan_reg;

    // checks
    `SSGP_ASSERT_IMPL(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `SSGP_ASSERT_NEXT(a_skid_drains, skid_valid_reg && mix.ready, out_valid_reg && !skid_valid_reg)
    `SSGP_ASSERT_IMPL(a_fmag_range, p4_valid_reg, p4_fmag_reg <= 17'd65536)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stereo_source_gain_pan testbench
// Drives listener/source position requests through the voice channel under
// random idling on both sides and one long stall on the mix side. Each result
// is checked field by field against its typed value or an in-bench fixed-point
// gain/pan model. max_distance is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssgp_pkg::*;

    localparam int PB = 24;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [15:0] volume;
        logic [15:0] pan;
    } mix_t;

    typedef struct {
        logic signed [PB-1:0] lx;
        logic signed [PB-1:0] ly;
        logic [15:0]          head;
        logic signed [PB-1:0] sx;
        logic signed [PB-1:0] sy;
        bit                   typed;
        mix_t                 want;
    } voice_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MD_W-1:0] cfg_wdata;

    ssgp_in_if #(.POSITION_BITS(PB)) voice_if ();
    ssgp_out_if mix_if ();

    stereo_source_gain_pan #(.POSITION_BITS(PB)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .voice    (voice_if),
        .mix      (mix_if)
    );

    mix_t            pending_mix[$];
    logic [MD_W-1:0] model_max_dist;
    int              errors;
    bit              calm;          // no idling in the closing stretch
    bit              hold_request;  // ask the mix side for one long stall

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // run limit
    initial
    begin
        #(8_000_000);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // gain/pan model
    // ------------------------------------------------------------------------
    function automatic longint unsigned quarter_sine(longint unsigned z);
        longint unsigned z2, inner, mid;
        z2    = (z * z) >> 14;
        inner = 64'(Q30_B_COEF) - ((64'(Q30_C_COEF) * z2) >> 14);
        mid   = 64'(Q30_HALF_PI) - ((inner * z2) >> 14);
        return (mid * z) >> 14;
    endfunction

    function automatic longint unit_ratio(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q   = mag / den;
        if (q > 65536)
            q = 65536;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic mix_t gain_pan(voice_row_t v);
        mix_t            m;
        longint          dx, dy, c, s, f, r, p;
        longint unsigned ax, ay, d2, e, den, vol, lo, sq, cq;
        int              sh;
        dx = longint'(v.sx) - longint'(v.lx);
        dy = longint'(v.sy) - longint'(v.ly);
        sh = 0;
        forever
        begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax < (64'd1 << 25) && ay < (64'd1 << 25))
                break;
            dx = dx >>> 1;
            dy = dy >>> 1;
            sh++;
        end
        d2 = ax * ax + ay * ay;
        if (d2 == 0)
        begin
            m.volume = 16'd65535;
            m.pan    = 16'd32768;
            return m;
        end
        e  = root64(d2 << 12);
        lo = v.head[13:0];
        sq = quarter_sine(lo);
        cq = quarter_sine(16384 - lo);
        case (v.head[15:14])
            2'd0:    begin c = cq;  s = sq;  end
            2'd1:    begin c = -sq; s = cq;  end
            2'd2:    begin c = -cq; s = -sq; end
            default: begin c = sq;  s = -cq; end
        endcase
        f   = unit_ratio(dx * c + dy * s, e << 16);
        r   = unit_ratio(dy * c - dx * s, e << 16);
        den = (64'(model_max_dist) << 6) + (e << sh);
        vol = (64'(model_max_dist) << 22) / den;
        if (vol > 65535)
            vol = 65535;
        // rear sources are attenuated
        if (f < 0)
            vol = (vol * unsigned'(131072 + f)) >> 17;
        p = (65536 + r) >>> 1;
        if (p > 65535)
            p = 65535;
        m.volume = vol[15:0];
        m.pan    = p[15:0];
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        mix_t want;
        if (rst_n && mix_if.valid && mix_if.ready)
        begin
            if (pending_mix.size() == 0)
                report_mismatch("unrequested result, volume", mix_if.volume, -1);
            else
            begin
                want = pending_mix.pop_front();
                if (mix_if.volume !== want.volume)
                    report_mismatch("volume", mix_if.volume, want.volume);
                if (mix_if.pan !== want.pan)
                    report_mismatch("pan", mix_if.pan, want.pan);
            end
        end
    end

    // mix side: random stall bursts plus one long hold-off
    initial
    begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held = 1'b0;
        mix_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                mix_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                mix_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_request(voice_row_t v);
        mix_t want;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            voice_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        voice_if.valid            <= 1'b1;
        voice_if.listener_x       <= v.lx;
        voice_if.listener_y       <= v.ly;
        voice_if.listener_heading <= v.head;
        voice_if.source_x         <= v.sx;
        voice_if.source_y         <= v.sy;
        do
            @(posedge clk);
        while (!voice_if.ready);
        want = v.typed ? v.want : gain_pan(v);
        pending_mix.push_back(want);
        @(negedge clk);
    endtask

    task automatic write_max_dist(logic [MD_W-1:0] value);
        voice_if.valid <= 1'b0;
        wait (pending_mix.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        model_max_dist = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic voice_row_t random_voice();
        voice_row_t v;
        logic [PB-1:0] ofs;
        v.typed = 1'b0;
        v.lx    = PB'($urandom);
        v.ly    = PB'($urandom);
        v.head  = 16'($urandom);
        v.sx    = PB'($urandom);
        v.sy    = PB'($urandom);
        case ($urandom_range(0, 5))
            0, 1:
            begin
                // nearby source, small deltas around the distance scale
                ofs = PB'($urandom_range(0, 1 << 14));
                v.sx = v.lx + ofs - PB'(1 << 13);
                ofs = PB'($urandom_range(0, 1 << 14));
                v.sy = v.ly + ofs - PB'(1 << 13);
            end
            2:
                v.head = {2'($urandom_range(0, 3)), 14'd0};
            3:
            begin
                // on one axis
                v.sy = v.ly;
                if ($urandom_range(0, 1))
                    v.sx = v.lx;
            end
            4:
                if ($urandom_range(0, 3) == 0)
                begin
                    v.sx = v.lx;
                    v.sy = v.ly;
                end
            default: ;
        endcase
        return v;
    endfunction

    voice_row_t directed[] = '{
        // zero distance, any heading
        '{24'sd0, 24'sd0, 16'd0, 24'sd0, 24'sd0, 1'b1, '{16'd65535, 16'd32768}},
        '{-24'sd8388608, 24'sd8388607, 16'hFFFF, -24'sd8388608, 24'sd8388607,
          1'b1, '{16'd65535, 16'd32768}},
        '{24'sd8388607, -24'sd8388608, 16'h8000, 24'sd8388607, -24'sd8388608,
          1'b1, '{16'd65535, 16'd32768}},
        // straight ahead at exactly the distance scale: half gain, centered
        '{24'sd0, 24'sd0, 16'd0, 24'sd12800, 24'sd0, 1'b1, '{16'd32768, 16'd32768}},
        // cardinal directions and the four headings
        '{24'sd0, 24'sd0, 16'd0, -24'sd12800, 24'sd0, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'd0, 24'sd0, 24'sd12800, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'd0, 24'sd0, -24'sd12800, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'h4000, 24'sd0, 24'sd12800, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'h4000, 24'sd12800, 24'sd0, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'h8000, 24'sd12800, 24'sd0, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'hC000, 24'sd12800, 24'sd0, 1'b0, '{0, 0}},
        '{24'sd100, 24'sd100, 16'h2000, 24'sd200, 24'sd200, 1'b0, '{0, 0}},
        '{24'sd0, 24'sd0, 16'h3FFF, 24'sd1, 24'sd0, 1'b0, '{0, 0}},
        // farthest apart, on both axes and along one axis
        '{-24'sd8388608, -24'sd8388608, 16'd0, 24'sd8388607, 24'sd8388607,
          1'b0, '{0, 0}},
        '{24'sd8388607, 24'sd8388607, 16'h6000, -24'sd8388608, -24'sd8388608,
          1'b0, '{0, 0}},
        '{24'sd8388607, 24'sd0, 16'hA5A5, -24'sd8388608, 24'sd0, 1'b0, '{0, 0}},
        // smallest nonzero distance
        '{24'sd5, 24'sd5, 16'h5A5A, 24'sd5, 24'sd4, 1'b0, '{0, 0}}
    };

    initial
    begin
        logic [MD_W-1:0] scales[5];
        errors = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        model_max_dist = MAX_DIST_RESET;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        voice_if.valid = 1'b0;
        voice_if.listener_x = '0;
        voice_if.listener_y = '0;
        voice_if.listener_heading = '0;
        voice_if.source_x = '0;
        voice_if.source_y = '0;
        wait (rst_n);
        @(negedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        // distance scale phases, extremes first
        scales = '{23'd1, 23'd8388607, 23'($urandom_range(1, 8388607)),
                   23'($urandom_range(1, 4096)), MAX_DIST_RESET};
        foreach (scales[p])
        begin
            write_max_dist(scales[p]);
            // repeat the untyped directed rows under the two extreme scales
            if (p < 2)
                foreach (directed[i])
                    if (!directed[i].typed)
                        send_request(directed[i]);
            for (int n = 0; n < 140; n++)
            begin
                if (p == 0 && n == 20)
                    hold_request = 1'b1;
                if (p == 4 && n == 40)
                    calm = 1'b1;
                send_request(random_voice());
            end
        end
        voice_if.valid <= 1'b0;

        wait (pending_mix.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/ssgp_pkg.sv
sv/ssgp_if.sv
sv/ssgp_sqrt.sv
sv/ssgp_div.sv
sv/stereo_source_gain_pan.sv
tb/tb.sv
